@@ rtl/oisr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oisr_pkg
// shared types and codes for the ordered id stack restack engine
// ----------------------------------------------------------------------------
package oisr_pkg;

    localparam int DEF_LIST_DEPTH = 64;
    localparam int POS_W = 12;
    localparam int ID_W = 64;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_RAISE  = 3'd2;
    localparam logic [2:0] CMD_LOWER  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_NOITEM = 3'd2;
    localparam logic [2:0] ST_NOSIB  = 3'd3;
    localparam logic [2:0] ST_SKIP   = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    typedef struct packed {
        logic                    shift_up;
        logic                    shift_dn;
        logic                    load;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] ld_pos;
        logic [ID_W-1:0]         ld_value;
    } shift_ctrl_t;

    function automatic logic is_legacy(input logic [ID_W-1:0] id);
        return id[ID_W-1:32] == '0;
    endfunction

endpackage
`default_nettype wire

@@ rtl/oisr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oisr_cell
// one list slot: holds an id, matches it, shifts from a neighbor or loads
// ----------------------------------------------------------------------------
module oisr_cell
    import oisr_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire [ID_W-1:0]         value_above,
    input  wire [ID_W-1:0]         value_below,
    input  shift_ctrl_t            ctrl,
    input  wire [ID_W-1:0]         item,
    input  wire [ID_W-1:0]         sib,
    input  wire signed [POS_W-1:0] fill,
    input  wire                    capture,
    output logic [ID_W-1:0]        value,
    output logic                   hit_item,
    output logic                   hit_sib,
    output logic                   legacy
);

    localparam logic signed [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [ID_W-1:0] value_reg;
    logic [ID_W-1:0] value_next;
    logic            hit_item_reg;
    logic            hit_sib_reg;
    logic            live;

    assign live = MY_POS < fill;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift_up && MY_POS >= ctrl.lo && MY_POS < ctrl.hi)
        begin
            value_next = value_above;
        end
        if (ctrl.shift_dn && MY_POS > ctrl.lo && MY_POS <= ctrl.hi)
        begin
            value_next = value_below;
        end
        if (ctrl.load && MY_POS == ctrl.ld_pos)
        begin
            value_next = ctrl.ld_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_item_reg <= 1'b0;
            hit_sib_reg  <= 1'b0;
        end
        else if (capture)
        begin
            hit_item_reg <= live && (value_reg == item);
            hit_sib_reg  <= live && (value_reg == sib);
        end
    end

    assign value    = value_reg;
    assign hit_item = hit_item_reg;
    assign hit_sib  = hit_sib_reg;
    assign legacy   = live && is_legacy(value_reg);

endmodule
`default_nettype wire

@@ rtl/ordered_id_stack_restack_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_id_stack_restack_engine_core
// ordered list of unique ids held in a row of slot cells
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken when start is high and busy is low. busy then
//   stays high until the result has been shown.
//   the result beat (changed, status, entry_count, read_value) is shown for
//   exactly one cycle with done high; done is set by a register as the
//   command leaves the scan state, after the match and resolve states.
//   one command is handled at a time; the next is not taken until the last
//   is through its steps: match in the cells, encode positions, scan the
//   legacy range, then one shift of the cell row.
//   the cells compare their ids and shift to a neighbor in parallel, so
//   the time per command does not depend on the list depth.
//   the receiver cannot stall; done must be sampled in its cycle.
//   reset clears the fill count and the control state; the slot contents
//   are left as they are and are never read beyond the fill count.
// ----------------------------------------------------------------------------
module ordered_id_stack_restack_engine_core
    import oisr_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [2:0]   cmd,
    input  wire [63:0]  item_id,
    input  wire [63:0]  sibling_id,
    input  wire [1:0]   apply_mode,
    input  wire [5:0]   read_index,
    output logic        done,
    output logic        changed,
    output logic [2:0]  status,
    output logic [6:0]  entry_count,
    output logic [63:0] read_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t state_reg;

    logic [2:0]              cmd_reg;
    logic [ID_W-1:0]         item_reg;
    logic [ID_W-1:0]         sib_reg;
    logic [1:0]              mode_reg;
    logic [5:0]              ridx_reg;
    logic signed [POS_W-1:0] fill_reg;
    logic signed [POS_W-1:0] cnt_reg;
    logic signed [POS_W-1:0] cnt_next;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] spos_reg;
    logic                    ifound_reg;
    logic                    sfound_reg;
    shift_ctrl_t             ctrl_reg;
    shift_ctrl_t             ctrl_next;
    shift_ctrl_t             cell_ctrl;
    logic                    done_reg;
    logic                    changed_reg;
    logic                    changed_next;
    logic [2:0]              status_reg;
    logic [2:0]              status_next;
    logic [ID_W-1:0]         rval_reg;
    logic [ID_W-1:0]         rval_next;

    logic [ID_W-1:0]         cell_value [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]   hit_item;
    logic [LIST_DEPTH-1:0]   hit_sib;
    logic [LIST_DEPTH-1:0]   legacy;

    logic signed [POS_W-1:0] pos_enc;
    logic signed [POS_W-1:0] spos_enc;
    logic signed [POS_W-1:0] dest;
    logic [LIST_DEPTH-1:0]   mask_up;
    logic [LIST_DEPTH-1:0]   mask_dn;
    logic [LIST_DEPTH-1:0]   mask_dn_rev;
    logic [LIST_DEPTH-1:0]   iso_up;
    logic [LIST_DEPTH-1:0]   iso_dn;
    logic signed [POS_W-1:0] low_up;
    logic signed [POS_W-1:0] high_dn;
    logic signed [POS_W-1:0] final_pos;
    logic                    free_move;
    logic                    item_leg;
    logic [ID_W-1:0]         rd_sel;

    assign cell_ctrl = (state_reg == S_APPLY) ? ctrl_reg : '0;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic [ID_W-1:0] above;
            logic [ID_W-1:0] below;
            if (gi == LIST_DEPTH - 1)
            begin : g_top
                assign above = '0;
            end
            else
            begin : g_mid
                assign above = cell_value[gi+1];
            end
            if (gi == 0)
            begin : g_bot
                assign below = '0;
            end
            else
            begin : g_up
                assign below = cell_value[gi-1];
            end
            oisr_cell #(
                .IDX(gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .value_above (above),
                .value_below (below),
                .ctrl        (cell_ctrl),
                .item        (item_reg),
                .sib         (sib_reg),
                .fill        (fill_reg),
                .capture     (state_reg == S_MATCH),
                .value       (cell_value[gi]),
                .hit_item    (hit_item[gi]),
                .hit_sib     (hit_sib[gi]),
                .legacy      (legacy[gi])
            );
        end
    endgenerate

    // position encode of the one-hot match flags
    always_comb
    begin
        pos_enc  = '0;
        spos_enc = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (hit_item[i])
            begin
                pos_enc = pos_enc | POS_W'(i);
            end
            if (hit_sib[i])
            begin
                spos_enc = spos_enc | POS_W'(i);
            end
        end
    end

    // destination, legacy range masks and nearest legacy ids
    always_comb
    begin
        if (sib_reg != '0)
        begin
            dest = (cmd_reg == CMD_RAISE) ? spos_reg : spos_reg - POS_W'(1);
        end
        else
        begin
            dest = (cmd_reg == CMD_RAISE) ? -POS_W'(1) : fill_reg - POS_W'(1);
        end
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            mask_up[i] = legacy[i] && ($signed(POS_W'(i)) > pos_reg)
                         && ($signed(POS_W'(i)) <= dest);
            mask_dn[i] = legacy[i] && ($signed(POS_W'(i)) > dest)
                         && ($signed(POS_W'(i)) < pos_reg);
        end
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            mask_dn_rev[i] = mask_dn[LIST_DEPTH-1-i];
        end
        iso_up  = mask_up & (~mask_up + 1'b1);
        iso_dn  = mask_dn_rev & (~mask_dn_rev + 1'b1);
        low_up  = '0;
        high_dn = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (iso_up[i])
            begin
                low_up = low_up | POS_W'(i);
            end
            if (iso_dn[i])
            begin
                high_dn = high_dn | POS_W'(LIST_DEPTH - 1 - i);
            end
        end
    end

    // read select
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (32'(ridx_reg) == 32'(i))
            begin
                rd_sel = cell_value[i];
            end
        end
    end

    assign item_leg  = is_legacy(item_reg);
    assign free_move = !mode_reg[0] || !item_leg;

    // decision
    always_comb
    begin
        status_next  = ST_OK;
        changed_next = 1'b0;
        cnt_next     = fill_reg;
        rval_next    = '0;
        ctrl_next    = '0;
        final_pos    = '0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (item_leg && mode_reg[0])
                begin
                    status_next = ST_SKIP;
                end
                else if (ifound_reg)
                begin
                    status_next = ST_DUP;
                end
                else if (fill_reg >= $signed(POS_W'(LIST_DEPTH)))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl_next.load     = 1'b1;
                    ctrl_next.ld_pos   = fill_reg;
                    ctrl_next.ld_value = item_reg;
                    cnt_next           = fill_reg + POS_W'(1);
                    changed_next       = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (item_leg && mode_reg[0])
                begin
                    status_next = ST_SKIP;
                end
                else if (!ifound_reg)
                begin
                    status_next = ST_NOITEM;
                end
                else
                begin
                    ctrl_next.shift_up = 1'b1;
                    ctrl_next.lo       = pos_reg;
                    ctrl_next.hi       = fill_reg - POS_W'(1);
                    cnt_next           = fill_reg - POS_W'(1);
                    changed_next       = 1'b1;
                end
            end
            CMD_RAISE, CMD_LOWER:
            begin
                if (!ifound_reg)
                begin
                    status_next = ST_NOITEM;
                end
                else if (sib_reg != '0 && !sfound_reg)
                begin
                    status_next = ST_NOSIB;
                end
                else if (pos_reg < dest)
                begin
                    if (mode_reg[1] && mask_up == '0)
                    begin
                        status_next = ST_SKIP;
                    end
                    else
                    begin
                        final_pos = (!free_move && mask_up != '0)
                                    ? low_up - POS_W'(1) : dest;
                        ctrl_next.shift_up = 1'b1;
                        ctrl_next.lo       = pos_reg;
                        ctrl_next.hi       = final_pos;
                        ctrl_next.load     = 1'b1;
                        ctrl_next.ld_pos   = final_pos;
                        ctrl_next.ld_value = item_reg;
                        changed_next       = final_pos != pos_reg;
                    end
                end
                else if (pos_reg > dest + POS_W'(1))
                begin
                    if (mode_reg[1] && mask_dn == '0)
                    begin
                        status_next = ST_SKIP;
                    end
                    else
                    begin
                        final_pos = (!free_move && mask_dn != '0)
                                    ? high_dn + POS_W'(1) : dest + POS_W'(1);
                        ctrl_next.shift_dn = 1'b1;
                        ctrl_next.lo       = final_pos;
                        ctrl_next.hi       = pos_reg;
                        ctrl_next.load     = 1'b1;
                        ctrl_next.ld_pos   = final_pos;
                        ctrl_next.ld_value = item_reg;
                        changed_next       = final_pos != pos_reg;
                    end
                end
            end
            CMD_READ:
            begin
                if (32'(ridx_reg) < 32'(fill_reg))
                begin
                    rval_next = rd_sel;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg  <= cmd;
            item_reg <= item_id;
            sib_reg  <= sibling_id;
            mode_reg <= apply_mode;
            ridx_reg <= read_index;
        end
        if (state_reg == S_RESOLVE)
        begin
            pos_reg  <= pos_enc;
            spos_reg <= spos_enc;
        end
        if (state_reg == S_SCAN)
        begin
            ctrl_reg    <= ctrl_next;
            changed_reg <= changed_next;
            status_reg  <= status_next;
            rval_reg    <= rval_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            ifound_reg <= 1'b0;
            sfound_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_RESOLVE;
                end
                S_RESOLVE:
                begin
                    ifound_reg <= |hit_item;
                    sfound_reg <= |hit_sib;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    fill_reg  <= cnt_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign changed     = changed_reg;
    assign status      = status_reg;
    assign entry_count = 7'(cnt_reg);
    assign read_value  = rval_reg;

endmodule
`default_nettype wire

@@ rtl/oisr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oisr_checker
// port-level checks of the command and result timing and of failed results
// ----------------------------------------------------------------------------
module oisr_checker
    import oisr_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire        changed,
    input wire [2:0]  status,
    input wire [63:0] read_value
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command beat");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result beat not at fixed latency");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    a_fail_nochange: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> !changed && read_value == '0)
        else $error("failed command reports a change");

endmodule

bind ordered_id_stack_restack_engine_core oisr_checker u_oisr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .changed    (changed),
    .status     (status),
    .read_value (read_value)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives add, remove, raise, lower and read commands into the restack engine
// and compares each result beat with a software copy of the ordered id list
// ----------------------------------------------------------------------------
module testbench;
    import oisr_pkg::*;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic        changed;
        logic [2:0]  status;
        logic [6:0]  entry_count;
        logic [63:0] read_value;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [63:0] item_id;
    logic [63:0] sibling_id;
    logic [1:0]  apply_mode;
    logic [5:0]  read_index;
    logic        done;
    logic        changed;
    logic [2:0]  status;
    logic [6:0]  entry_count;
    logic [63:0] read_value;

    logic [63:0] stack_ids[DEPTH];
    int          stack_fill;
    outcome_t    pending_outcomes[$];
    int          error_count;
    int          idle_cycles;
    bit          gaps_on;
    logic [63:0] id_pool[24];

    ordered_id_stack_restack_engine_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .item_id(item_id), .sibling_id(sibling_id), .apply_mode(apply_mode),
        .read_index(read_index), .done(done), .changed(changed),
        .status(status), .entry_count(entry_count), .read_value(read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit legacy_id(logic [63:0] id);
        return id[63:32] == 32'd0;
    endfunction

    function automatic int find_id(logic [63:0] id);
        for (int i = 0; i < stack_fill; i++)
            if (stack_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic bit shift_entry(logic [63:0] id, int from, int dest,
                                       logic [1:0] mode, output logic [2:0] st);
        bit free_move;
        bit seen;
        int i;
        free_move = !mode[0] || !legacy_id(id);
        st = ST_OK;
        seen = 1'b0;
        if (from < dest) begin
            for (i = from + 1; i <= dest; i++)
                if (legacy_id(stack_ids[i]))
                    seen = 1'b1;
            if (mode[1] && !seen)
            begin
                st = ST_SKIP;
                return 1'b0;
            end
            for (i = from; i < dest; i++)
            begin
                if (!free_move && legacy_id(stack_ids[i + 1]))
                    break;
                stack_ids[i] = stack_ids[i + 1];
            end
            stack_ids[i] = id;
            return i != from;
        end
        if (from > dest + 1) begin
            for (i = dest + 1; i < from; i++)
                if (legacy_id(stack_ids[i]))
                    seen = 1'b1;
            if (mode[1] && !seen)
            begin
                st = ST_SKIP;
                return 1'b0;
            end
            for (i = from; i > dest + 1; i--)
            begin
                if (!free_move && legacy_id(stack_ids[i - 1]))
                    break;
                stack_ids[i] = stack_ids[i - 1];
            end
            stack_ids[i] = id;
            return i != from;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t apply_command(logic [2:0] c, logic [63:0] id,
            logic [63:0] sib, logic [1:0] mode, logic [5:0] idx);
        outcome_t o;
        int pos;
        int spos;
        int dest;
        o.changed = 1'b0;
        o.status = ST_OK;
        o.read_value = '0;
        case (c)
            CMD_ADD:
                if (legacy_id(id) && mode[0])
                    o.status = ST_SKIP;
                else if (find_id(id) >= 0)
                    o.status = ST_DUP;
                else if (stack_fill >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    stack_ids[stack_fill] = id;
                    stack_fill++;
                    o.changed = 1'b1;
                end
            CMD_REMOVE:
            begin
                pos = find_id(id);
                if (legacy_id(id) && mode[0])
                    o.status = ST_SKIP;
                else if (pos < 0)
                    o.status = ST_NOITEM;
                else
                begin
                    for (int k = pos; k + 1 < stack_fill; k++)
                        stack_ids[k] = stack_ids[k + 1];
                    stack_fill--;
                    o.changed = 1'b1;
                end
            end
            CMD_RAISE, CMD_LOWER:
            begin
                pos = find_id(id);
                spos = find_id(sib);
                if (pos < 0)
                    o.status = ST_NOITEM;
                else if (sib != 0 && spos < 0)
                    o.status = ST_NOSIB;
                else
                begin
                    if (sib != 0)
                        dest = (c == CMD_RAISE) ? spos : spos - 1;
                    else
                        dest = (c == CMD_RAISE) ? -1 : stack_fill - 1;
                    o.changed = shift_entry(id, pos, dest, mode, o.status);
                end
            end
            CMD_READ:
                if (idx < stack_fill)
                    o.read_value = stack_ids[idx];
            default: ;
        endcase
        o.entry_count = stack_fill[6:0];
        return o;
    endfunction

    // result beat checker
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat");
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (changed !== exp_o.changed || status !== exp_o.status ||
                    entry_count !== exp_o.entry_count ||
                    read_value !== exp_o.read_value) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp %0b %0d %0d %h got %0b %0d %0d %h",
                                 exp_o.changed, exp_o.status, exp_o.entry_count,
                                 exp_o.read_value, changed, status, entry_count,
                                 read_value);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // start stays high between back-to-back commands; it drops only for a gap
    task automatic send_command(logic [2:0] c, logic [63:0] id, logic [63:0] sib,
                                logic [1:0] mode, logic [5:0] idx);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        item_id <= id;
        sibling_id <= sib;
        apply_mode <= mode;
        read_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(apply_command(c, id, sib, mode, idx));
    endtask

    function automatic logic [63:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        return id_pool[$urandom_range(0, 23)];
    endfunction

    task automatic test_directed();
        send_command(CMD_READ, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 2'd0, 6'd0);
        send_command(CMD_ADD, 64'h0000_0000_FFFF_FFFF, 64'd0, 2'd1, 6'd0);
        send_command(CMD_ADD, 64'h0000_0000_FFFF_FFFF, 64'd0, 2'd0, 6'd0);
        send_command(CMD_ADD, 64'h0000_0001_0000_0000, 64'd0, 2'd3, 6'd0);
        send_command(CMD_ADD, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_ADD, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_RAISE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 2'd1, 6'd0);
        send_command(CMD_LOWER, 64'h0000_0001_0000_0000, 64'd0, 2'd2, 6'd0);
        send_command(CMD_LOWER, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 6'd0);
        send_command(CMD_RAISE, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_RAISE, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_RAISE, 64'h1234, 64'd0, 2'd0, 6'd0);
        send_command(CMD_RAISE, 64'd0, 64'h5555, 2'd0, 6'd0);
        send_command(CMD_LOWER, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_REMOVE, 64'd0, 64'd0, 2'd1, 6'd0);
        send_command(CMD_REMOVE, 64'h77, 64'd0, 2'd0, 6'd0);
        send_command(CMD_READ, 64'd0, 64'd0, 2'd0, 6'd63);
        send_command(CMD_READ, 64'd0, 64'd0, 2'd0, 6'd2);
        send_command(3'd5, '1, '1, 2'd3, 6'd63);
        send_command(3'd7, 64'd0, 64'd0, 2'd0, 6'd0);
        send_command(CMD_REMOVE, 64'd0, 64'd0, 2'd0, 6'd0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < DEPTH + 2; i++)
            send_command(CMD_ADD, {32'($urandom_range(0, 1)), 32'(i + 500)},
                         64'd0, 2'd0, 6'd0);
        send_command(CMD_READ, 64'd0, 64'd0, 2'd0, 6'd63);
        for (int i = 0; i < 40; i++)
            send_command(3'($urandom_range(2, 3)), stack_ids[$urandom_range(0, 63)],
                         $urandom_range(0, 4) == 0 ? 64'd0 :
                         stack_ids[$urandom_range(0, 63)],
                         2'($urandom_range(0, 3)), 6'd0);
        while (stack_fill > 0)
            send_command(CMD_REMOVE, stack_ids[$urandom_range(0, stack_fill - 1)],
                         64'd0, 2'd0, 6'd0);
    endtask

    task automatic test_random_mix(int count);
        logic [2:0] c;
        for (int i = 0; i < count; i++)
        begin
            c = $urandom_range(0, 9) < 3 ? CMD_ADD : 3'($urandom_range(1, 7));
            if (c > CMD_READ && $urandom_range(0, 3) != 0)
                c = CMD_RAISE;
            send_command(c, pick_id(), $urandom_range(0, 5) == 0 ? 64'd0 : pick_id(),
                         2'($urandom_range(0, 3)), 6'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        item_id = '0;
        sibling_id = '0;
        apply_mode = '0;
        read_index = '0;
        error_count = 0;
        idle_cycles = 0;
        stack_fill = 0;
        gaps_on = 1'b1;
        for (int i = 0; i < 24; i++)
            id_pool[i] = (i % 2) ? {$urandom, $urandom} : 64'($urandom);
        id_pool[0] = 64'd0;
        id_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random_mix(600);
        gaps_on = 1'b0;
        test_random_mix(150);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
